/* hdl/qva_pkg.sv */
// Shared constants, types and helpers for the quaternion and vector ALU.
package qva_pkg;

   // Number format
   localparam int DATA_WIDTH    = 32;
   localparam int FRACTION_BITS = 16;

   // Internal widths
   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int SUM_W  = 2 * DATA_WIDTH + 2;
   localparam int SQ_W   = 2 * DATA_WIDTH + 1;
   localparam int ROOT_W = DATA_WIDTH + 1;
   localparam int QUO_W  = FRACTION_BITS + 2;
   localparam int NUM_W  = DATA_WIDTH + FRACTION_BITS + 1;
   localparam int DEN_W  = ROOT_W + 1;

   // Stream word widths, padded to whole bytes
   localparam int REQ_W = ((9 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_W = ((4 * DATA_WIDTH + 7) / 8) * 8;

   // Rounding constant for products: half an LSB of the result
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRACTION_BITS - 1);

   // Negated terms of the Hamilton product, bit index component*4 + term
   localparam logic [15:0] HAM_NEG = 16'h428E;

   typedef enum logic [2:0] {
      CMD_ADD,
      CMD_SUB,
      CMD_SCALE,
      CMD_CONJ,
      CMD_PROD,
      CMD_VPROD,
      CMD_LENGTH,
      CMD_NORM
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_SAT,
      ST_ZERO
   } status_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  flag;
   } sat_type;

   // Item state that rides along the pipeline
   typedef struct packed {
      cmd_type                     cmd;
      logic [3:0][DATA_WIDTH-1:0]  res;
      logic                        sat;
      logic [3:0][DATA_WIDTH-1:0]  a;
   } item_type;

   // Clamp a wide signed value to the data range
   function automatic sat_type saturate(input logic signed [SUM_W-1:0] v);
      sat_type             r;
      logic [SUM_W-DATA_WIDTH:0] top;
      top = v[SUM_W-1:DATA_WIDTH-1];
      if (top == '0 || top == '1) begin
         r.value = v[DATA_WIDTH-1:0];
         r.flag  = 1'b0;
      end else begin
         r.flag  = 1'b1;
         r.value = v[SUM_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                              : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

/* hdl/qva_mac.sv */
// Multiply and accumulate front end: products, sums, rounding, saturation.
module qva_mac
   import qva_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  cmd_type                    in_cmd,
   input  logic [3:0][DATA_WIDTH-1:0] in_a,
   input  logic [3:0][DATA_WIDTH-1:0] in_b,
   input  logic [DATA_WIDTH-1:0]      in_scale,
   output logic                       out_valid,
   output item_type                   out_item,
   output logic [SQ_W-1:0]            out_sumsq
);

   // Stage 1 signals
   logic signed [DATA_WIDTH-1:0] opb [4][4];
   logic signed [PROD_W-1:0]     prod_in [4][4];
   logic signed [PROD_W-1:0]     prod_ff [4][4];
   logic signed [SUM_W-1:0]      lin [4];
   sat_type                      lsat [4];
   item_type                     item1_in, item1_ff;
   logic                         v1_ff;

   // Stage 2 signals
   logic signed [SUM_W-1:0]      term [4][4];
   logic signed [SUM_W-1:0]      pa_in [4], pb_in [4], pa_ff [4], pb_ff [4];
   logic signed [PROD_W-1:0]     diag_ff [4];
   logic [SQ_W-1:0]              sqa_in, sqb_in, sqa_ff, sqb_ff;
   item_type                     item2_ff;
   logic                         v2_ff;

   // Stage 3 signals
   logic signed [SUM_W-1:0]      tot_in [4], tot_ff [4];
   logic [SQ_W-1:0]              sumsq_in, sumsq3_ff;
   item_type                     item3_ff;
   logic                         v3_ff;

   // Stage 4 signals
   logic signed [SUM_W-1:0]      shr [4];
   sat_type                      psat [4];
   item_type                     item4_in, item4_ff;
   logic [SQ_W-1:0]              sumsq4_ff;
   logic                         v4_ff;

   // Select the right multiplicand of each product
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            if (j == 0 && in_cmd == CMD_VPROD) begin
               opb[i][j] = '0;
            end else begin
               opb[i][j] = $signed(in_b[j]);
            end
            if (i == j) begin
               if (in_cmd == CMD_SCALE) begin
                  opb[i][j] = $signed(in_scale);
               end else if (in_cmd == CMD_LENGTH || in_cmd == CMD_NORM) begin
                  opb[i][j] = $signed(in_a[i]);
               end
            end
            prod_in[i][j] = $signed(in_a[i]) * opb[i][j];
         end
      end
   end

   // Linear commands: add, subtract, conjugate
   always_comb begin
      item1_in     = '0;
      item1_in.cmd = in_cmd;
      item1_in.a   = in_a;
      for (int i = 0; i < 4; i++) begin
         case (in_cmd)
            CMD_ADD: lin[i] = $signed(in_a[i]) + $signed(in_b[i]);
            CMD_SUB: lin[i] = $signed(in_a[i]) - $signed(in_b[i]);
            CMD_CONJ: begin
               if (i == 0) begin
                  lin[i] = $signed(in_a[i]);
               end else begin
                  lin[i] = -$signed(in_a[i]);
               end
            end
            default: lin[i] = '0;
         endcase
         lsat[i]         = saturate(lin[i]);
         item1_in.res[i] = lsat[i].value;
      end
      item1_in.sat = lsat[0].flag | lsat[1].flag | lsat[2].flag | lsat[3].flag;
   end

   // Signed Hamilton terms and pair sums
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int t = 0; t < 4; t++) begin
            if (HAM_NEG[k*4+t]) begin
               term[k][t] = -SUM_W'(prod_ff[t][k^t]);
            end else begin
               term[k][t] = SUM_W'(prod_ff[t][k^t]);
            end
         end
         pa_in[k] = term[k][0] + term[k][1];
         pb_in[k] = term[k][2] + term[k][3];
      end
      sqa_in = SQ_W'($unsigned(prod_ff[0][0])) + SQ_W'($unsigned(prod_ff[1][1]));
      sqb_in = SQ_W'($unsigned(prod_ff[2][2])) + SQ_W'($unsigned(prod_ff[3][3]));
   end

   // Final sums with rounding constant
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (item2_ff.cmd == CMD_SCALE) begin
            tot_in[k] = SUM_W'(diag_ff[k]) + ROUND_HALF;
         end else begin
            tot_in[k] = pa_ff[k] + pb_ff[k] + ROUND_HALF;
         end
      end
      sumsq_in = sqa_ff + sqb_ff;
   end

   // Drop fraction bits and clamp for scale and products
   always_comb begin
      item4_in = item3_ff;
      for (int k = 0; k < 4; k++) begin
         shr[k]  = tot_ff[k] >>> FRACTION_BITS;
         psat[k] = saturate(shr[k]);
      end
      if (item3_ff.cmd == CMD_SCALE || item3_ff.cmd == CMD_PROD ||
          item3_ff.cmd == CMD_VPROD) begin
         for (int k = 0; k < 4; k++) begin
            item4_in.res[k] = psat[k].value;
         end
         item4_in.sat = psat[0].flag | psat[1].flag | psat[2].flag | psat[3].flag;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         item1_ff  <= item1_in;
         prod_ff   <= prod_in;
         item2_ff  <= item1_ff;
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         for (int k = 0; k < 4; k++) begin
            diag_ff[k] <= prod_ff[k][k];
         end
         sqa_ff    <= sqa_in;
         sqb_ff    <= sqb_in;
         item3_ff  <= item2_ff;
         tot_ff    <= tot_in;
         sumsq3_ff <= sumsq_in;
         item4_ff  <= item4_in;
         sumsq4_ff <= sumsq3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_item  = item4_ff;
   assign out_sumsq = sumsq4_ff;

endmodule

/* hdl/qva_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module qva_isqrt
   import qva_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  item_type          in_item,
   input  logic [SQ_W-1:0]   in_sumsq,
   output logic              out_valid,
   output item_type          out_item,
   output logic [ROOT_W-1:0] out_root
);

   localparam int REM_W = ROOT_W + 2;
   localparam int RAD_W = 2 * ROOT_W;

   logic              v_ff    [ROOT_W];
   item_type          item_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_step
      logic              v_src;
      item_type          item_src;
      logic [REM_W-1:0]  rem_src, rem_sh, trial, rem_in;
      logic [ROOT_W-1:0] root_src, root_in;
      logic [RAD_W-1:0]  rad_src, rad_in;
      logic              take;

      if (g == 0) begin : g_first
         assign v_src    = in_valid;
         assign item_src = in_item;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = RAD_W'(in_sumsq);
      end else begin : g_next
         assign v_src    = v_ff[g-1];
         assign item_src = item_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign rad_src  = rad_ff[g-1];
      end

      // Bring down two radicand bits and try the next root bit
      assign rem_sh  = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
      assign trial   = {root_src, 2'b01};
      assign take    = rem_sh >= trial;
      assign rem_in  = take ? rem_sh - trial : rem_sh;
      assign root_in = {root_src[ROOT_W-2:0], take};
      assign rad_in  = {rad_src[RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[g] <= item_src;
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            rad_ff[g]  <= rad_in;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_item  = item_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule

/* hdl/qva_div.sv */
// Normalize divider lanes and final result selection with the output register.
module qva_div
   import qva_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  item_type                   in_item,
   input  logic [ROOT_W-1:0]          in_root,
   output logic                       out_valid,
   output logic [3:0][DATA_WIDTH-1:0] out_res,
   output status_type                 out_status
);

   localparam int DR_W = DEN_W + 1;

   // Setup stage
   logic [DATA_WIDTH-1:0] mag [4];
   logic [NUM_W-1:0]      num_in [4], snum_ff [4];
   logic [3:0]            neg_in, sneg_ff;
   item_type              sitem_ff;
   logic [ROOT_W-1:0]     sroot_ff;
   logic                  sv_ff;

   // Division steps
   logic                  v_ff    [QUO_W];
   item_type              item_ff [QUO_W];
   logic [ROOT_W-1:0]     root_ff [QUO_W];
   logic [3:0]            neg_ff  [QUO_W];
   logic [DR_W-1:0]       rem_ff  [QUO_W][4];
   logic [QUO_W-1:0]      lo_ff   [QUO_W][4];

   // Output stage
   logic signed [SUM_W-1:0]    qv [4];
   sat_type                    qsat [4];
   sat_type                    lsat;
   logic [3:0][DATA_WIDTH-1:0] res_in, res_ff;
   status_type                 stat_in, stat_ff;
   logic                       ov_ff;
   item_type                   fitem;
   logic [ROOT_W-1:0]          froot;

   // Form numerator 2*|a|*2^F + L for each lane
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         neg_in[i] = in_item.a[i][DATA_WIDTH-1];
         mag[i]    = neg_in[i] ? (~in_item.a[i] + 1'b1) : in_item.a[i];
         num_in[i] = (NUM_W'(mag[i]) << (FRACTION_BITS + 1)) + NUM_W'(in_root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else if (en) begin
         sv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sitem_ff <= in_item;
         sroot_ff <= in_root;
         sneg_ff  <= neg_in;
         snum_ff  <= num_in;
      end
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_step
      logic              v_src;
      item_type          item_src;
      logic [ROOT_W-1:0] root_src;
      logic [3:0]        neg_src;
      logic [DR_W-1:0]   rem_src [4];
      logic [QUO_W-1:0]  lo_src  [4];
      logic [DR_W-1:0]   den;
      logic [DR_W-1:0]   rem_sh  [4];
      logic [DR_W-1:0]   rem_in  [4];
      logic [QUO_W-1:0]  lo_in   [4];

      if (g == 0) begin : g_first
         assign v_src    = sv_ff;
         assign item_src = sitem_ff;
         assign root_src = sroot_ff;
         assign neg_src  = sneg_ff;
         for (genvar i = 0; i < 4; i++) begin : g_lane
            assign rem_src[i] = DR_W'(snum_ff[i][NUM_W-1:QUO_W]);
            assign lo_src[i]  = snum_ff[i][QUO_W-1:0];
         end
      end else begin : g_next
         assign v_src    = v_ff[g-1];
         assign item_src = item_ff[g-1];
         assign root_src = root_ff[g-1];
         assign neg_src  = neg_ff[g-1];
         for (genvar i = 0; i < 4; i++) begin : g_lane
            assign rem_src[i] = rem_ff[g-1][i];
            assign lo_src[i]  = lo_ff[g-1][i];
         end
      end

      assign den = DR_W'({root_src, 1'b0});

      // Shift in one numerator bit, subtract when it fits
      always_comb begin
         for (int i = 0; i < 4; i++) begin
            rem_sh[i] = {rem_src[i][DR_W-2:0], lo_src[i][QUO_W-1]};
            if (rem_sh[i] >= den) begin
               rem_in[i] = rem_sh[i] - den;
               lo_in[i]  = {lo_src[i][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_sh[i];
               lo_in[i]  = {lo_src[i][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[g] <= item_src;
            root_ff[g] <= root_src;
            neg_ff[g]  <= neg_src;
            for (int i = 0; i < 4; i++) begin
               rem_ff[g][i] <= rem_in[i];
               lo_ff[g][i]  <= lo_in[i];
            end
         end
      end
   end

   assign fitem = item_ff[QUO_W-1];
   assign froot = root_ff[QUO_W-1];

   // Pick the result by command and set status
   always_comb begin
      lsat = saturate(SUM_W'(froot));
      for (int i = 0; i < 4; i++) begin
         qv[i] = SUM_W'(lo_ff[QUO_W-1][i]);
         if (neg_ff[QUO_W-1][i]) begin
            qv[i] = -qv[i];
         end
         qsat[i] = saturate(qv[i]);
      end
      case (fitem.cmd)
         CMD_LENGTH: begin
            res_in    = '0;
            res_in[0] = lsat.value;
            stat_in   = lsat.flag ? ST_SAT : ST_OK;
         end
         CMD_NORM: begin
            if (froot == '0) begin
               res_in  = '0;
               stat_in = ST_ZERO;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  res_in[i] = qsat[i].value;
               end
               stat_in = (qsat[0].flag | qsat[1].flag | qsat[2].flag | qsat[3].flag)
                         ? ST_SAT : ST_OK;
            end
         end
         default: begin
            res_in  = fitem.res;
            stat_in = fitem.sat ? ST_SAT : ST_OK;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= v_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff  <= res_in;
         stat_ff <= stat_in;
      end
   end

   assign out_valid  = ov_ff;
   assign out_res    = res_ff;
   assign out_status = stat_ff;

endmodule

/* hdl/quaternion_vector_alu.sv */
// Top level of the quaternion and four-vector ALU with stream ports.
//
// Pipelined Q16.16 quaternion/vector unit: one request word may enter every
// cycle and one response word leaves per request, in order. Every command
// takes the same path: four multiply/accumulate stages, a 33-stage square
// root (one root bit per stage), then a setup stage, an 18-step divider for
// normalize and the output register. Sustained rate is one word per cycle
// while response words are taken.
// When the response word is not taken the whole pipeline holds in place.
module quaternion_vector_alu
   import qva_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor
   input  logic [REQ_W-1:0] req_tdata,
   // command
   input  logic [2:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // r_w, r_x, r_y, r_z
   output logic [RSP_W-1:0] rsp_tdata,
   // status
   output logic [1:0]       rsp_tuser
);

   logic                       en;
   logic [3:0][DATA_WIDTH-1:0] a, b;
   logic [DATA_WIDTH-1:0]      scale;
   logic                       mac_valid, sq_valid;
   item_type                   mac_item, sq_item;
   logic [SQ_W-1:0]            mac_sumsq;
   logic [ROOT_W-1:0]          sq_root;
   logic [3:0][DATA_WIDTH-1:0] res;
   status_type                 status;

   // Advance the pipeline unless the output word is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Unpack request word
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a[i] = req_tdata[i*DATA_WIDTH +: DATA_WIDTH];
         b[i] = req_tdata[(4+i)*DATA_WIDTH +: DATA_WIDTH];
      end
      scale = req_tdata[8*DATA_WIDTH +: DATA_WIDTH];
   end

   qva_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_cmd    (cmd_type'(req_tuser)),
      .in_a      (a),
      .in_b      (b),
      .in_scale  (scale),
      .out_valid (mac_valid),
      .out_item  (mac_item),
      .out_sumsq (mac_sumsq)
   );

   qva_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mac_valid),
      .in_item   (mac_item),
      .in_sumsq  (mac_sumsq),
      .out_valid (sq_valid),
      .out_item  (sq_item),
      .out_root  (sq_root)
   );

   qva_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (sq_valid),
      .in_item    (sq_item),
      .in_root    (sq_root),
      .out_valid  (rsp_tvalid),
      .out_res    (res),
      .out_status (status)
   );

   // Pack response word
   assign rsp_tdata = RSP_W'(res);
   assign rsp_tuser = status;

endmodule

/* tb/quaternion_vector_alu_test.sv */
// Self-checking testbench for the quaternion and four-vector ALU stream unit.
`timescale 1ns / 1ps

module quaternion_vector_alu_test;
   import qva_pkg::*;

   typedef struct packed {
      cmd_type                    cmd;
      logic [3:0][DATA_WIDTH-1:0] a;
      logic [3:0][DATA_WIDTH-1:0] b;
      logic [DATA_WIDTH-1:0]      s;
   } quat_req_type;

   typedef struct packed {
      logic [3:0][DATA_WIDTH-1:0] r;
      status_type                 st;
   } quat_rsp_type;

   typedef struct packed {
      quat_req_type req;
      logic         fixed;
      quat_rsp_type want;
   } stim_row_type;

   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;
   localparam logic [31:0] ONE  = 32'h0001_0000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [2:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;

   stim_row_type directed[$];
   quat_rsp_type pending_rsp[$];
   int           errors = 0;
   int           words_sent = 0;
   bit           hold_rsp = 0;

   quaternion_vector_alu dut (.*);

   // Free-running clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #3ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Clamp a wide signed value to the data range
   function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic sat);
      if (v > 128'sh7fff_ffff) begin
         sat = 1;
         return MAXV;
      end else if (v < -128'sh8000_0000) begin
         sat = 1;
         return MINV;
      end
      return v[31:0];
   endfunction

   // Compute the expected response word for one request
   function automatic quat_rsp_type quat_eval(input quat_req_type q);
      logic signed [127:0] a[4], b[4], v[4], s;
      logic [127:0]        sum, len, t, num, den, m;
      logic                sat;
      quat_rsp_type        o;
      sat = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = {{96{q.a[i][31]}}, q.a[i]};
         b[i] = {{96{q.b[i][31]}}, q.b[i]};
         v[i] = 0;
      end
      s = {{96{q.s[31]}}, q.s};
      if (q.cmd == CMD_VPROD) b[0] = 0;
      o.st = ST_OK;
      case (q.cmd)
         CMD_ADD: for (int i = 0; i < 4; i++) v[i] = a[i] + b[i];
         CMD_SUB: for (int i = 0; i < 4; i++) v[i] = a[i] - b[i];
         CMD_SCALE: for (int i = 0; i < 4; i++) v[i] = (a[i] * s + 128'sd32768) >>> 16;
         CMD_CONJ: begin
            v[0] = a[0];
            for (int i = 1; i < 4; i++) v[i] = -a[i];
         end
         CMD_PROD, CMD_VPROD: begin
            v[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
            v[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
            v[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
            v[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
            for (int i = 0; i < 4; i++) v[i] = (v[i] + 128'sd32768) >>> 16;
         end
         default: begin
            sum = 0;
            for (int i = 0; i < 4; i++) sum = sum + 128'(a[i] * a[i]);
            len = 0;
            for (int k = 32; k >= 0; k--) begin
               t = len | (128'd1 << k);
               if (t * t <= sum) len = t;
            end
            if (q.cmd == CMD_LENGTH) begin
               v[0] = len;
            end else if (len == 0) begin
               o.st = ST_ZERO;
            end else begin
               den = len << 1;
               for (int i = 0; i < 4; i++) begin
                  m = a[i] < 0 ? -a[i] : a[i];
                  num = (m << 17) + len;
                  v[i] = a[i] < 0 ? -(num / den) : num / den;
               end
            end
         end
      endcase
      for (int i = 0; i < 4; i++) o.r[i] = clamp(v[i], sat);
      if (o.st == ST_OK && sat) o.st = ST_SAT;
      return o;
   endfunction

   function automatic logic [31:0] pick_val();
      case ($urandom_range(0, 7))
         0: return MAXV;
         1: return MINV;
         2: return 0;
         3: return $urandom_range(0, 1) ? ONE : -ONE;
         4, 5: return 32'($signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic row(input cmd_type c, input logic [31:0] aw, ax, ay, az,
                      input logic [31:0] bw, bx, by, bz, s);
      stim_row_type t;
      t.req = '{c, {az, ay, ax, aw}, {bz, by, bx, bw}, s};
      t.fixed = 0;
      t.want = '0;
      directed.push_back(t);
   endtask

   // Attach a typed expectation to the last row
   task automatic known(input logic [31:0] rw, rx, ry, rz, input status_type st);
      directed[$].fixed = 1;
      directed[$].want = '{{rz, ry, rx, rw}, st};
   endtask

   // Offer one word and hold it until taken
   task automatic send(input quat_req_type q, input logic fixed, input quat_rsp_type want);
      req_tvalid <= 1;
      req_tuser  <= q.cmd;
      req_tdata  <= {q.s, q.b[3], q.b[2], q.b[1], q.b[0], q.a[3], q.a[2], q.a[1], q.a[0]};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(fixed ? want : quat_eval(q));
      words_sent++;
      if (words_sent == 300) hold_rsp = 1;
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 80) : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   // Stimulus
   initial begin
      quat_req_type q;
      int           n;
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = CMD_ADD;
      row(CMD_ADD, MAXV, MAXV, MINV, 0, MAXV, 1, MINV, 0, 0);
      known(MAXV, MAXV, MINV, 0, ST_SAT);
      row(CMD_ADD, 5, -3, ONE, 0, 7, 3, ONE, 0, MAXV);
      known(12, 0, 32'h0002_0000, 0, ST_OK);
      row(CMD_SUB, MINV, 0, MAXV, 10, 1, MINV, MINV, 4, 0);
      known(MINV, MAXV, MAXV, 6, ST_SAT);
      row(CMD_SCALE, ONE, MAXV, MINV, -ONE, 0, 0, 0, 0, ONE);
      known(ONE, MAXV, MINV, -ONE, ST_OK);
      row(CMD_SCALE, MAXV, MINV, 3, -3, MAXV, 0, 0, 0, MAXV);
      row(CMD_SCALE, 1, -1, 32'h8000, 32'h18000, 0, 0, 0, 0, 32'h8000);
      row(CMD_CONJ, MINV, MINV, MAXV, 0, 0, 0, 0, 0, 0);
      known(MINV, MAXV, MINV + 1, 0, ST_SAT);
      row(CMD_PROD, ONE, 0, 0, 0, 32'h1234, 32'h5678, -7, 9, 0);
      known(32'h1234, 32'h5678, -7, 9, ST_OK);
      row(CMD_PROD, 0, ONE, 0, 0, 0, 0, ONE, 0, 0);
      row(CMD_PROD, MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, 0);
      row(CMD_PROD, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 0);
      row(CMD_VPROD, MAXV, 123, -ONE, 77, MAXV, ONE, 2, -ONE, 0);
      row(CMD_VPROD, ONE, ONE, ONE, ONE, MINV, ONE, ONE, ONE, 0);
      row(CMD_LENGTH, 0, 0, 0, 0, MAXV, MAXV, MAXV, MAXV, MAXV);
      known(0, 0, 0, 0, ST_OK);
      row(CMD_LENGTH, MINV, MINV, MINV, MINV, 0, 0, 0, 0, 0);
      known(MAXV, 0, 0, 0, ST_SAT);
      row(CMD_LENGTH, 3, 4, 0, 0, 0, 0, 0, 0, 0);
      known(5, 0, 0, 0, ST_OK);
      row(CMD_LENGTH, MAXV, 1, -1, MAXV, 0, 0, 0, 0, 0);
      row(CMD_NORM, 0, 0, 0, 0, MAXV, MINV, 1, 1, MAXV);
      known(0, 0, 0, 0, ST_ZERO);
      row(CMD_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0);
      known(ONE, 0, 0, 0, ST_OK);
      row(CMD_NORM, MINV, 0, 0, 0, 0, 0, 0, 0, 0);
      known(-ONE, 0, 0, 0, ST_OK);
      row(CMD_NORM, MAXV, MINV, MAXV, MINV, 0, 0, 0, 0, 0);
      row(CMD_NORM, 3, -4, 1, 0, 0, 0, 0, 0, 0);
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed table
      foreach (directed[i]) send(directed[i].req, directed[i].fixed, directed[i].want);

      // Drain completely before the random part
      req_tvalid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);

      // Random part
      for (n = 0; n < 850; n++) begin
         q.cmd = cmd_type'($urandom_range(0, 7));
         for (int i = 0; i < 4; i++) begin
            q.a[i] = pick_val();
            q.b[i] = pick_val();
         end
         q.s = pick_val();
         if (q.cmd >= CMD_LENGTH && $urandom_range(0, 9) == 0) q.a = '0;
         send(q, 0, '0);
      end
      req_tvalid <= 0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Response side readiness, with one long hold-off
   initial begin
      rsp_tready = 0;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 80) : $urandom_range(1, 3))
               @(posedge clock);
         end else begin
            rsp_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Compare each taken response word with the oldest expectation
   always @(posedge clock) begin
      quat_rsp_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with no expectation");
            errors++;
         end else begin
            w = pending_rsp.pop_front();
            for (int i = 0; i < 4; i++)
               if (rsp_tdata[32*i +: 32] !== w.r[i]) begin
                  $error("r[%0d] expected %h actual %h", i, w.r[i], rsp_tdata[32*i +: 32]);
                  errors++;
               end
            if (rsp_tuser !== w.st) begin
               $error("status expected %0d actual %0d", w.st, rsp_tuser);
               errors++;
            end
         end
      end
   end

endmodule
